/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("concurrent assertion failed");

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("concurrent assertion failed");

`define ASSERT_IMPLY_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("concurrent assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_IMPLY_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/dsam_pkg.sv */
// ----------------------------------------------------------------------------
// dsam_pkg
// Widths, register indexes, reset values and control structs of the
// dual sensor average monitor.
// ----------------------------------------------------------------------------
package dsam_pkg;

  localparam int unsigned DSAM_WINDOW = 5;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned TEMP_W      = 24;
  localparam int unsigned DIFF_W      = 23;
  // sum * 512: counts to Q8 degrees is 512 / 3 per count
  localparam int unsigned SCALE_SHIFT = 9;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_LEVEL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAN_ON_LEVEL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAN_OFF_LEVEL = 2'd3;

  localparam logic [DIFF_W-1:0]        RST_DIFF_LIMIT    = 23'd1280;
  localparam logic signed [TEMP_W-1:0] RST_WARN_LEVEL    = 24'sd24320;
  localparam logic signed [TEMP_W-1:0] RST_FAN_ON_LEVEL  = 24'sd23040;
  localparam logic signed [TEMP_W-1:0] RST_FAN_OFF_LEVEL = 24'sd21760;

  typedef struct packed {
    logic [DIFF_W-1:0]        diff_limit;
    logic signed [TEMP_W-1:0] warn_level;
    logic signed [TEMP_W-1:0] fan_on_level;
    logic signed [TEMP_W-1:0] fan_off_level;
  } cfg_regs_t;

  typedef struct packed {
    logic push;
    logic mul_en;
    logic fix_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic load;
    logic eval;
  } merge_ctrl_t;

endpackage

/* src/dsam_lane.sv */
// ----------------------------------------------------------------------------
// dsam_lane
// One sensor channel: sample ring with running sum and fill count, then
// a two-stage reciprocal divide giving trunc(sum * 512 / (3 * fill)).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsam_lane import dsam_pkg::*; #(
  parameter int unsigned WINDOW = DSAM_WINDOW
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lane_ctrl_t               ctrl,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                     seen,
  output logic signed [TEMP_W-1:0] temp
);

  localparam int unsigned POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned NW     = SUM_W + SCALE_SHIFT;
  localparam int unsigned RCP_W  = NW - 1;
  localparam int unsigned PW     = NW + RCP_W;
  localparam int unsigned DEN_W  = $clog2(3 * WINDOW + 1);
  localparam int unsigned QM_W   = RCP_W + DEN_W;
  localparam int unsigned TAB_N  = 2 ** FILL_W;

  logic signed [SAMPLE_W-1:0] ring_r [WINDOW];
  logic [POS_W-1:0]           wpos_r, wpos_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic                       seen_r;

  logic signed [SUM_W-1:0]    samp_ext, old_ext;
  logic                       full;

  logic [RCP_W-1:0]           recip_tab [TAB_N];
  logic [SUM_W-1:0]           mag;
  logic [NW-1:0]              n_cur, n_r;
  logic                       neg_r;
  logic [DEN_W-1:0]           den_nxt, den_r;
  logic [PW-1:0]              prod_nxt, prod_r;

  logic [RCP_W-1:0]           q0, q;
  logic [QM_W-1:0]            qm;
  logic [NW-1:0]              rem;
  logic [TEMP_W-1:0]          q_lo;
  logic signed [TEMP_W-1:0]   temp_nxt, temp_r;

  // Reciprocal table floor(2^NW / (3 * fill)); fill of zero reads zero.
  for (genvar Gi = 0; Gi < TAB_N; Gi++) begin : g_recip
    if (Gi >= 1 && Gi <= WINDOW) begin : g_used
      localparam longint unsigned Den = 3 * Gi;
      localparam longint unsigned Rcp = (64'd1 << NW) / Den;
      assign recip_tab[Gi] = RCP_W'(Rcp);
    end else begin : g_unused
      assign recip_tab[Gi] = '0;
    end
  end

  // Push: running sum drops the overwritten reading once the ring is full.
  assign samp_ext = SUM_W'(sample);
  assign old_ext  = SUM_W'(ring_r[wpos_r]);
  assign full     = (fill_r == FILL_W'(WINDOW));

  always_comb begin
    sum_nxt  = full ? (sum_r + samp_ext - old_ext) : (sum_r + samp_ext);
    wpos_nxt = (wpos_r == POS_W'(WINDOW - 1)) ? '0 : wpos_r + 1'b1;
    fill_nxt = full ? fill_r : fill_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0;
      fill_r <= '0;
      sum_r  <= '0;
      seen_r <= 1'b0;
    end else if (ctrl.push) begin
      wpos_r <= wpos_nxt;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      ring_r[wpos_r] <= sample;
    end
  end

  // Multiply stage: magnitude times reciprocal.
  assign mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign n_cur    = {mag, {SCALE_SHIFT{1'b0}}};
  assign den_nxt  = (DEN_W'(fill_r) << 1) + DEN_W'(fill_r);
  assign prod_nxt = PW'(n_cur) * PW'(recip_tab[fill_r]);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
      n_r    <= n_cur;
      neg_r  <= sum_r[SUM_W-1];
      den_r  <= den_nxt;
    end
  end

  // Correction stage: estimate is low by at most one.
  always_comb begin
    q0       = prod_r[PW-1:NW];
    qm       = QM_W'(q0) * QM_W'(den_r);
    rem      = n_r - qm[NW-1:0];
    q        = (rem >= NW'(den_r)) ? q0 + 1'b1 : q0;
    q_lo     = q[TEMP_W-1:0];
    temp_nxt = neg_r ? -q_lo : q_lo;
  end

  always_ff @(posedge clk) begin
    if (ctrl.fix_en) begin
      temp_r <= temp_nxt;
    end
  end

  assign seen = seen_r;
  assign temp = temp_r;

  `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_r <= FILL_W'(WINDOW))
  `ASSERT_IMPLY(a_wpos_tracks_fill, clk, rst_n, !full, FILL_W'(wpos_r) == fill_r)

endmodule

/* src/dsam_merge.sv */
// ----------------------------------------------------------------------------
// dsam_merge
// Combines both lane temperatures: mean, difference alarm, warning and
// fan crossings against the previous mean; holds the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsam_merge import dsam_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  merge_ctrl_t              ctrl,
  input  cfg_regs_t                cfg,
  input  logic signed [TEMP_W-1:0] temp_a,
  input  logic signed [TEMP_W-1:0] temp_b,
  input  logic                     out_stall,
  output logic                     free,
  output logic                     out_valid,
  output logic                     out_evaluated,
  output logic signed [TEMP_W-1:0] out_temp_a,
  output logic signed [TEMP_W-1:0] out_temp_b,
  output logic signed [TEMP_W-1:0] out_mean_temp,
  output logic                     out_diff_alarm,
  output logic                     out_warn_rise,
  output logic                     out_warn_fall,
  output logic                     out_fan_on,
  output logic                     out_fan_off
);

  logic signed [TEMP_W:0]   sum2, diff;
  logic [TEMP_W:0]          abs_diff;
  logic signed [TEMP_W-1:0] mean;
  logic                     alarm, rise, fall, fon, foff;

  logic                     out_valid_r;
  logic                     eval_r;
  logic signed [TEMP_W-1:0] ta_r, tb_r, mean_r;
  logic                     alarm_r, rise_r, fall_r, fon_r, foff_r;
  logic signed [TEMP_W-1:0] prev_mean_r;

  always_comb begin
    sum2     = (TEMP_W + 1)'(temp_a) + (TEMP_W + 1)'(temp_b);
    diff     = (TEMP_W + 1)'(temp_a) - (TEMP_W + 1)'(temp_b);
    abs_diff = diff[TEMP_W] ? (TEMP_W + 1)'(-diff) : (TEMP_W + 1)'(diff);
    // arithmetic shift: floor of the half
    mean     = sum2[TEMP_W:1];
    alarm    = abs_diff > (TEMP_W + 1)'(cfg.diff_limit);
    rise     = (mean > cfg.warn_level) && (prev_mean_r <= cfg.warn_level);
    fall     = (mean < cfg.warn_level) && (prev_mean_r >= cfg.warn_level);
    fon      = (mean > cfg.fan_on_level) && (prev_mean_r <= cfg.fan_on_level);
    foff     = !fon && (mean < cfg.fan_off_level) && (prev_mean_r >= cfg.fan_off_level);
  end

  assign free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_mean_r <= '0;
    end else if (ctrl.load) begin
      out_valid_r <= 1'b1;
      if (ctrl.eval) begin
        prev_mean_r <= mean;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload of a non-evaluating item is all zero.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      eval_r  <= ctrl.eval;
      ta_r    <= ctrl.eval ? temp_a : '0;
      tb_r    <= ctrl.eval ? temp_b : '0;
      mean_r  <= ctrl.eval ? mean : '0;
      alarm_r <= ctrl.eval && alarm;
      rise_r  <= ctrl.eval && rise;
      fall_r  <= ctrl.eval && fall;
      fon_r   <= ctrl.eval && fon;
      foff_r  <= ctrl.eval && foff;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_evaluated  = eval_r;
  assign out_temp_a     = ta_r;
  assign out_temp_b     = tb_r;
  assign out_mean_temp  = mean_r;
  assign out_diff_alarm = alarm_r;
  assign out_warn_rise  = rise_r;
  assign out_warn_fall  = fall_r;
  assign out_fan_on     = fon_r;
  assign out_fan_off    = foff_r;

  `ASSERT_IMPLY_NEXT(a_prev_hold, clk, rst_n, ctrl.load && !ctrl.eval, $stable(prev_mean_r))

endmodule

/* src/dual_sensor_average_monitor.sv */
// ----------------------------------------------------------------------------
// dual_sensor_average_monitor
// Each input beat may carry a new reading from sensor A, sensor B or both;
// each sensor keeps a ring of its last WINDOW readings. Once both sensors
// have reported and the beat carries a new reading, both averages are
// recomputed as signed Q8 degrees, with their floor mean, a difference
// alarm, warning-level crossings and fan on/off events against the
// previous mean; otherwise the result beat has evaluated low and all
// other fields zero. One result beat comes out per input beat. An item
// is registered in turn by the ring update, the reciprocal multiply in
// each lane, the remainder correction and the merge into the output
// register. The next item is accepted in the cycle after the merge,
// even while the result still waits downstream; only a result that is
// still held when the next one is ready stretches this. in_stall is
// high while an item is in flight. Configuration writes are always
// taken (cfg_ready stays high) and must only be issued while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_sensor_average_monitor import dsam_pkg::*; #(
  parameter int unsigned WINDOW = DSAM_WINDOW
) (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_a_valid,
  input  logic signed [SAMPLE_W-1:0] in_a_sample,
  input  logic                     in_b_valid,
  input  logic signed [SAMPLE_W-1:0] in_b_sample,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_evaluated,
  output logic signed [TEMP_W-1:0] out_temp_a,
  output logic signed [TEMP_W-1:0] out_temp_b,
  output logic signed [TEMP_W-1:0] out_mean_temp,
  output logic                     out_diff_alarm,
  output logic                     out_warn_rise,
  output logic                     out_warn_fall,
  output logic                     out_fan_on,
  output logic                     out_fan_off,

  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic        eval_r, eval_nxt;
  logic        in_beat;
  cfg_regs_t   cfg_r, cfg_nxt;

  lane_ctrl_t  ctrl_a, ctrl_b;
  merge_ctrl_t mctrl;
  logic        seen_a, seen_b;
  logic signed [TEMP_W-1:0] temp_a, temp_b;
  logic        out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIFF_LIMIT:    cfg_nxt.diff_limit    = cfg_data[DIFF_W-1:0];
        CFG_WARN_LEVEL:    cfg_nxt.warn_level    = cfg_data;
        CFG_FAN_ON_LEVEL:  cfg_nxt.fan_on_level  = cfg_data;
        CFG_FAN_OFF_LEVEL: cfg_nxt.fan_off_level = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.diff_limit    <= RST_DIFF_LIMIT;
      cfg_r.warn_level    <= RST_WARN_LEVEL;
      cfg_r.fan_on_level  <= RST_FAN_ON_LEVEL;
      cfg_r.fan_off_level <= RST_FAN_OFF_LEVEL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    eval_nxt  = eval_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = ST_MUL;
          eval_nxt  = (in_a_valid || seen_a) && (in_b_valid || seen_b) &&
                      (in_a_valid || in_b_valid);
        end
      end
      ST_MUL:  state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_OUT;
      ST_OUT: begin
        // hold until the result register can take the beat
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      eval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      eval_r  <= eval_nxt;
    end
  end

  always_comb begin
    ctrl_a.push   = in_beat && in_a_valid;
    ctrl_a.mul_en = (state_r == ST_MUL);
    ctrl_a.fix_en = (state_r == ST_FIX);
    ctrl_b.push   = in_beat && in_b_valid;
    ctrl_b.mul_en = (state_r == ST_MUL);
    ctrl_b.fix_en = (state_r == ST_FIX);
    mctrl.load    = (state_r == ST_OUT) && out_free;
    mctrl.eval    = eval_r;
  end

  dsam_lane #(
    .WINDOW (WINDOW)
  ) u_lane_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl_a),
    .sample (in_a_sample),
    .seen   (seen_a),
    .temp   (temp_a)
  );

  dsam_lane #(
    .WINDOW (WINDOW)
  ) u_lane_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl_b),
    .sample (in_b_sample),
    .seen   (seen_b),
    .temp   (temp_b)
  );

  dsam_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (mctrl),
    .cfg            (cfg_r),
    .temp_a         (temp_a),
    .temp_b         (temp_b),
    .out_stall      (out_stall),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_evaluated  (out_evaluated),
    .out_temp_a     (out_temp_a),
    .out_temp_b     (out_temp_b),
    .out_mean_temp  (out_mean_temp),
    .out_diff_alarm (out_diff_alarm),
    .out_warn_rise  (out_warn_rise),
    .out_warn_fall  (out_warn_fall),
    .out_fan_on     (out_fan_on),
    .out_fan_off    (out_fan_off)
  );

  `ASSERT_IMPLY_NEXT(a_accept_starts, clk, rst_n, in_beat, state_r == ST_MUL)
  `ASSERT_IMPLY_NEXT(a_out_hold, clk, rst_n, (state_r == ST_OUT) && !out_free, state_r == ST_OUT)

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_sensor_average_monitor testbench
// A short table of beats opens the run: reset behavior, sample extremes,
// ring wrap and beats with no new sample. Randomized phases under different
// threshold settings and flow-control patterns follow. A behavioral model of
// the rings, averages and crossing detectors predicts each result beat not typed in the table.
// ----------------------------------------------------------------------------
module testbench import dsam_pkg::*;;

  localparam int CH_A          = 0;
  localparam int CH_B          = 1;
  localparam int SETTLE_CYCLES = 12;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int PHASE_BEATS   = 84;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct packed {
    logic                     evaluated;
    logic signed [TEMP_W-1:0] temp_a;
    logic signed [TEMP_W-1:0] temp_b;
    logic signed [TEMP_W-1:0] mean_temp;
    logic                     diff_alarm;
    logic                     warn_rise;
    logic                     warn_fall;
    logic                     fan_on;
    logic                     fan_off;
  } sensor_result_t;

  typedef struct packed {
    logic                       a_valid;
    logic signed [SAMPLE_W-1:0] a_sample;
    logic                       b_valid;
    logic signed [SAMPLE_W-1:0] b_sample;
    logic                       typed;
    sensor_result_t             result;
  } sensor_beat_t;

  localparam sensor_result_t IDLE_RESULT = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_a_valid = 1'b0;
  logic signed [SAMPLE_W-1:0] in_a_sample = '0;
  logic                       in_b_valid = 1'b0;
  logic signed [SAMPLE_W-1:0] in_b_sample = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_evaluated;
  logic signed [TEMP_W-1:0] out_temp_a;
  logic signed [TEMP_W-1:0] out_temp_b;
  logic signed [TEMP_W-1:0] out_mean_temp;
  logic                     out_diff_alarm;
  logic                     out_warn_rise;
  logic                     out_warn_fall;
  logic                     out_fan_on;
  logic                     out_fan_off;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model state
  logic signed [SAMPLE_W-1:0] hist [2][DSAM_WINDOW];
  int unsigned                hist_pos [2];
  int unsigned                hist_fill [2];
  bit                         hist_seen [2];
  longint                     last_mean = 0;
  cfg_regs_t                  thresholds = '{RST_DIFF_LIMIT, RST_WARN_LEVEL,
                                             RST_FAN_ON_LEVEL, RST_FAN_OFF_LEVEL};

  sensor_beat_t   beat_q [$];
  sensor_result_t expect_q [$];
  int             beats_owed = 0;
  int             errors = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int          gap_max = 0;
  int          sample_center = 140;
  int          sample_spread = 25;

  dual_sensor_average_monitor uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < DSAM_WINDOW; i++) hist[c][i] = '0;
      hist_pos[c] = 0;
      hist_fill[c] = 0;
      hist_seen[c] = 1'b0;
    end
  end

  function automatic void push_reading(int ch, logic signed [SAMPLE_W-1:0] v);
    hist[ch][hist_pos[ch]] = v;
    hist_pos[ch] = (hist_pos[ch] + 1 >= DSAM_WINDOW) ? 0 : hist_pos[ch] + 1;
    if (hist_fill[ch] < DSAM_WINDOW) hist_fill[ch]++;
    hist_seen[ch] = 1'b1;
  endfunction

  // sum * 512 / (3 * fill), truncated toward zero
  function automatic longint channel_q8(int ch);
    longint sum = 0;
    for (int i = 0; i < hist_fill[ch]; i++) sum += hist[ch][i];
    if (hist_fill[ch] == 0) return 0;
    return (sum * 512) / (3 * longint'(hist_fill[ch]));
  endfunction

  function automatic sensor_result_t model_sensor_beat(sensor_beat_t bt);
    sensor_result_t r;
    longint ta, tb, mean, d;
    longint warn, fon_lvl, foff_lvl, dlim;
    r = IDLE_RESULT;
    if (bt.a_valid) push_reading(CH_A, bt.a_sample);
    if (bt.b_valid) push_reading(CH_B, bt.b_sample);
    if (!(hist_seen[CH_A] && hist_seen[CH_B] && (bt.a_valid || bt.b_valid))) return r;
    warn = thresholds.warn_level;
    fon_lvl = thresholds.fan_on_level;
    foff_lvl = thresholds.fan_off_level;
    dlim = thresholds.diff_limit;
    ta = channel_q8(CH_A);
    tb = channel_q8(CH_B);
    d = (ta > tb) ? ta - tb : tb - ta;
    mean = (ta + tb) >>> 1;
    r.evaluated = 1'b1;
    r.temp_a = ta[TEMP_W-1:0];
    r.temp_b = tb[TEMP_W-1:0];
    r.mean_temp = mean[TEMP_W-1:0];
    r.diff_alarm = d > dlim;
    r.warn_rise = mean > warn && last_mean <= warn;
    r.warn_fall = mean < warn && last_mean >= warn;
    r.fan_on = mean > fon_lvl && last_mean <= fon_lvl;
    r.fan_off = !r.fan_on && mean < foff_lvl && last_mean >= foff_lvl;
    last_mean = mean;
    return r;
  endfunction

  function automatic sensor_beat_t beat(bit av, int a, bit bv, int b, bit typed = 1'b0,
                                        sensor_result_t res = IDLE_RESULT);
    sensor_beat_t bt;
    bt.a_valid = av;
    bt.a_sample = a[SAMPLE_W-1:0];
    bt.b_valid = bv;
    bt.b_sample = b[SAMPLE_W-1:0];
    bt.typed = typed;
    bt.result = res;
    return bt;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 60) begin
      v = sample_center + int'($urandom_range(2 * sample_spread)) - sample_spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end else if (sel < 85) begin
      v = $urandom;
    end else begin
      case ($urandom_range(3))
        0: v = 32767;
        1: v = -32768;
        2: v = 0;
        default: v = -1;
      endcase
    end
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic sensor_beat_t random_beat();
    int sel;
    sel = $urandom_range(99);
    return beat(sel < 70 || (sel >= 95 && 1'b0), pick_sample(),
                (sel < 45) || (sel >= 70 && sel < 95), pick_sample());
  endfunction

  // input side: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    sensor_beat_t cur;
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expect_q.push_back(cur.typed ? cur.result : model_sensor_beat(cur));
        if (cur.typed) void'(model_sensor_beat(cur));
        beats_owed--;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          cur = beat_q.pop_front();
          in_valid <= 1'b1;
          in_a_valid <= cur.a_valid;
          in_a_sample <= cur.a_sample;
          in_b_valid <= cur.b_valid;
          in_b_sample <= cur.b_sample;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    int tick;
    tick++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(3) != 0);
      default:     out_stall <= (tick % 7) < 3;
    endcase
  end

  task automatic report_field(string fname, logic signed [TEMP_W-1:0] e,
                              logic signed [TEMP_W-1:0] g);
    if (e !== g) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, fname, e, g);
    end
  endtask

  // result side
  always @(posedge clk) begin
    sensor_result_t got, exp;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_evaluated, out_temp_a, out_temp_b, out_mean_temp, out_diff_alarm,
              out_warn_rise, out_warn_fall, out_fan_on, out_fan_off};
      if (expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none actual %h", $time, got);
      end else begin
        exp = expect_q.pop_front();
        report_field("evaluated", exp.evaluated, got.evaluated);
        report_field("temp_a", exp.temp_a, got.temp_a);
        report_field("temp_b", exp.temp_b, got.temp_b);
        report_field("mean_temp", exp.mean_temp, got.mean_temp);
        report_field("diff_alarm", exp.diff_alarm, got.diff_alarm);
        report_field("warn_rise", exp.warn_rise, got.warn_rise);
        report_field("warn_fall", exp.warn_fall, got.warn_fall);
        report_field("fan_on", exp.fan_on, got.fan_on);
        report_field("fan_off", exp.fan_off, got.fan_off);
      end
    end
  end

  // abort when no beat moves on any channel for too long
  always @(posedge clk) begin
    int quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_MAX) begin
      $display("dual_sensor_average_monitor test failed");
      $finish;
    end
  end

  task automatic queue_beat(sensor_beat_t bt);
    beat_q.push_back(bt);
    beats_owed++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (beats_owed != 0 || expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIFF_LIMIT:   thresholds.diff_limit = d[DIFF_W-1:0];
      CFG_WARN_LEVEL:   thresholds.warn_level = d;
      CFG_FAN_ON_LEVEL: thresholds.fan_on_level = d;
      default:          thresholds.fan_off_level = d;
    endcase
  endtask

  task automatic write_regs(logic [CFG_DATA_W-1:0] dl, logic [CFG_DATA_W-1:0] wl,
                            logic [CFG_DATA_W-1:0] onl, logic [CFG_DATA_W-1:0] offl);
    write_reg(CFG_DIFF_LIMIT, dl);
    write_reg(CFG_WARN_LEVEL, wl);
    write_reg(CFG_FAN_ON_LEVEL, onl);
    write_reg(CFG_FAN_OFF_LEVEL, offl);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n, int center, int spread, stall_mode_t sm, int gap);
    sample_center = center;
    sample_spread = spread;
    stall_mode = sm;
    gap_max = gap;
    for (int k = 0; k < n; k++) queue_beat(random_beat());
    wait_idle();
  endtask

  localparam logic [CFG_DATA_W-1:0] LVL_MAX = 24'h7FFFFF;
  localparam logic [CFG_DATA_W-1:0] LVL_MIN = 24'h800000;

  initial begin
    logic [CFG_DATA_W-1:0] r_diff, r_warn, r_on, r_off;
    longint center;
    sensor_beat_t dir_rows [$];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; rows with a typed result are checked against it as is
    stall_mode = STALL_LIGHT;
    gap_max = 2;
    dir_rows = {
      beat(1, 150, 0, 0, 1, IDLE_RESULT),
      beat(0, 0, 0, 0, 1, IDLE_RESULT),
      beat(0, 0, 1, 150, 1, '{1'b1, 24'sd25600, 24'sd25600, 24'sd25600,
                             1'b0, 1'b1, 1'b0, 1'b1, 1'b0}),
      beat(0, 0, 0, 0, 1, IDLE_RESULT),
      beat(1, 32767, 1, 32767),
      beat(1, -32768, 1, -32768),
      beat(1, 32767, 0, 0),
      beat(0, 0, 1, -32768),
      beat(1, -32768, 1, 32767),
      beat(1, -1, 1, 0),
      beat(1, -2, 1, -3),
      beat(1, 1, 1, -1),
      beat(1, 142, 1, 143),
      beat(1, 142, 1, 144),
      beat(1, 145, 1, 141),
      beat(1, 150, 1, 150),
      beat(1, 150, 1, 150),
      beat(1, 120, 1, 110),
      beat(1, 100, 1, 100),
      beat(1, 90, 1, 100),
      beat(0, 0, 0, 0),
      beat(1, 140, 0, 0),
      beat(0, 0, 1, 200)
    };
    foreach (dir_rows[i]) queue_beat(dir_rows[i]);
    wait_idle();

    run_random(PHASE_BEATS, 140, 25, STALL_NONE, 0);

    // extremes; bit 23 of the diff limit write must be dropped
    write_regs(LVL_MIN, LVL_MAX, LVL_MAX, LVL_MIN);
    run_random(PHASE_BEATS, 0, 200, STALL_LIGHT, 3);

    write_regs(24'h7FFFFF, LVL_MIN, LVL_MIN, LVL_MAX);
    run_random(PHASE_BEATS, -100, 300, STALL_HEAVY, 8);

    // fan off level above fan on level: off is suppressed on the same beat
    write_regs(24'd500, 24'd24000, 24'd20000, 24'd26000);
    run_random(PHASE_BEATS, 138, 20, STALL_PERIODIC, 2);

    r_diff = $urandom;
    r_warn = $urandom;
    r_on = $urandom;
    r_off = $urandom;
    write_regs(r_diff, r_warn, r_on, r_off);
    center = longint'($signed(r_warn)) * 3 / 512;
    if (center > 32000) center = 32000;
    if (center < -32000) center = -32000;
    run_random(PHASE_BEATS, int'(center), 40, STALL_LIGHT, 0);

    r_diff = $urandom_range(0, 3000);
    r_warn = $urandom_range(17000, 30000);
    r_on = $urandom_range(17000, 30000);
    r_off = $urandom_range(17000, 30000);
    write_regs(r_diff, r_warn, r_on, r_off);
    run_random(PHASE_BEATS, 140, 30, STALL_HEAVY, 4);

    write_regs(RST_DIFF_LIMIT, RST_WARN_LEVEL, RST_FAN_ON_LEVEL, RST_FAN_OFF_LEVEL);
    run_random(PHASE_BEATS, 135, 25, STALL_PERIODIC, 12);

    if (errors == 0 && expect_q.size() == 0)
      $display("dual_sensor_average_monitor test passed");
    else
      $display("dual_sensor_average_monitor test failed");
    $finish;
  end

endmodule
